// ===== hw/rtl/set_assoc_cache_fifo_random_defines.svh =====
// Assertion macros for the set-associative cache block
`ifndef SET_ASSOC_CACHE_FIFO_RANDOM_DEFINES_SVH
`define SET_ASSOC_CACHE_FIFO_RANDOM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SACF_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sacf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SACF_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sacf: next-cycle check failed");

`endif

// ===== hw/rtl/sacf_pkg.sv =====
package sacf_pkg;

	localparam int ADDR_W    = 32;
	localparam int TAG_W     = 16;
	localparam int AGE_W     = 8;
	localparam int CNT_W     = 32;
	localparam int LFSR_W    = 16;
	localparam int OUT_WAY_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam logic [LFSR_W-1:0] SEED_DEFAULT = 16'd44257;
	localparam logic [LFSR_W-1:0] LFSR_TAPS    = 16'hB400;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_en;
		logic rd_en;
		logic update;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/sacf_ctrl.sv =====
module sacf_ctrl
	import sacf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Sequence clear pass, set read and set write-back
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.rd_en = 1'b1;
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.out_free) begin
					cmd.update = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hw/rtl/sacf_dpath.sv =====
module sacf_dpath
	import sacf_pkg::*;
#(
	parameter int NUM_SETS    = 1024,
	parameter int NUM_WAYS    = 4,
	parameter int OFFSET_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [ADDR_W-1:0]    address,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 hit,
	output logic [OUT_WAY_W-1:0] way,
	output logic                 evicted,
	output logic [CNT_W-1:0]     reference_count,
	output logic [CNT_W-1:0]     miss_count
);

	// Set and way counts are powers of two
	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int WAY_BITS = $clog2(NUM_WAYS);

	typedef struct packed {
		logic [NUM_WAYS-1:0]            valid;
		logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
		logic [NUM_WAYS-1:0][AGE_W-1:0] age;
	} row_t;

	row_t mem [NUM_SETS];

	logic [SET_BITS-1:0] clr_cnt_q;
	logic [SET_BITS-1:0] set_s1;
	logic [TAG_W-1:0]    tag_s1;
	row_t                row_s1;

	logic              policy_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [CNT_W-1:0]  refs_q;
	logic [CNT_W-1:0]  misses_q;
	logic              rsp_valid_q;
	logic              hit_q;
	logic [OUT_WAY_W-1:0] way_q;
	logic              evicted_q;

	logic [ADDR_W-1:0]   addr_hi;
	logic [SET_BITS-1:0] req_set;
	logic [TAG_W-1:0]    req_tag;

	logic                lk_hit;
	logic [WAY_BITS-1:0] hit_idx;
	logic                has_free;
	logic [WAY_BITS-1:0] free_idx;
	logic [WAY_BITS-1:0] fifo_idx;
	logic [AGE_W-1:0]    best_age;
	logic [LFSR_W-1:0]   lfsr_nxt;
	logic                do_evict;
	logic [WAY_BITS-1:0] vic_idx;
	logic [WAY_BITS-1:0] sel_idx;
	logic [WAY_BITS+OUT_WAY_W-1:0] sel_ext;
	row_t                new_row;

	logic                wr_en;
	logic [SET_BITS-1:0] wr_addr;
	row_t                wr_data;

	// Split the address into set index and tag
	assign addr_hi = address >> (OFFSET_BITS + SET_BITS);
	assign req_set = address[OFFSET_BITS +: SET_BITS];
	assign req_tag = addr_hi[TAG_W-1:0];

	// Search the set: first matching way, first free way, oldest way
	always_comb begin
		lk_hit   = 1'b0;
		hit_idx  = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_s1.valid[w] && (row_s1.tag[w] == tag_s1)) begin
				lk_hit  = 1'b1;
				hit_idx = WAY_BITS'(w);
			end
			if (!row_s1.valid[w]) begin
				has_free = 1'b1;
				free_idx = WAY_BITS'(w);
			end
		end
		best_age = '0;
		fifo_idx = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (row_s1.age[w] > best_age) begin
				best_age = row_s1.age[w];
				fifo_idx = WAY_BITS'(w);
			end
		end
	end

	// Advance the Galois LFSR by one step
	assign lfsr_nxt = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	assign do_evict = !lk_hit && !has_free;
	assign vic_idx  = has_free ? free_idx :
	                  (policy_q ? lfsr_nxt[WAY_BITS-1:0] : fifo_idx);
	assign sel_idx  = lk_hit ? hit_idx : vic_idx;
	assign sel_ext  = {{OUT_WAY_W{1'b0}}, sel_idx};

	// Build the write-back row: age the others on a FIFO eviction, install the line
	always_comb begin
		new_row = row_s1;
		if (!lk_hit) begin
			if (do_evict && !policy_q) begin
				for (int w = 0; w < NUM_WAYS; w++) begin
					if (WAY_BITS'(w) != vic_idx) begin
						new_row.age[w] = row_s1.age[w] + AGE_W'(1);
					end
				end
			end
			new_row.valid[vic_idx] = 1'b1;
			new_row.tag[vic_idx]   = tag_s1;
			new_row.age[vic_idx]   = '0;
		end
	end

	// Select clear sweep or set write-back
	assign wr_en   = cmd.clear_en || cmd.update;
	assign wr_addr = cmd.clear_en ? clr_cnt_q : set_s1;
	assign wr_data = cmd.clear_en ? row_t'('0) : new_row;

	// Tag memory: one row per set
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			row_s1 <= mem[req_set];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold the request fields for the lookup cycle
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			set_s1 <= req_set;
			tag_s1 <= req_tag;
		end
	end

	// Step the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_en) begin
			clr_cnt_q <= clr_cnt_q + SET_BITS'(1);
		end
	end

	assign sts.clear_last = (clr_cnt_q == SET_BITS'(NUM_SETS - 1));
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	// Configuration registers and victim LFSR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
			lfsr_q   <= SEED_DEFAULT;
		end else if (cfg_we) begin
			if (cfg_index == REG_POLICY) begin
				policy_q <= cfg_data[0];
			end
			if (cfg_index == REG_SEED) begin
				lfsr_q <= (cfg_data != '0) ? cfg_data : SEED_DEFAULT;
			end
		end else if (cmd.update && do_evict && policy_q) begin
			lfsr_q <= lfsr_nxt;
		end
	end

	// Counters double as the count fields of the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refs_q      <= '0;
			misses_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				refs_q      <= refs_q + CNT_W'(1);
				misses_q    <= misses_q + CNT_W'(!lk_hit);
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q     <= lk_hit;
			way_q     <= sel_ext[OUT_WAY_W-1:0];
			evicted_q <= do_evict;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign hit             = hit_q;
	assign way             = way_q;
	assign evicted         = evicted_q;
	assign reference_count = refs_q;
	assign miss_count      = misses_q;

endmodule

// ===== hw/rtl/set_assoc_cache_fifo_random.sv =====
// An accepted address word has its set row read into a register; the lookup result is
// loaded into the output register at the write-back of that row. One word is taken at
// a time: the row is read, then written back, and while a pending result is stalled
// the write-back, and the next accept, are held.
// Reset: asynchronous, active low; a clearing pass then invalidates all NUM_SETS rows
// (1024 by default) with req_stall high; configuration writes are taken meanwhile.
`include "set_assoc_cache_fifo_random_defines.svh"

module set_assoc_cache_fifo_random
	import sacf_pkg::*;
#(
	parameter int NUM_SETS    = 1024,
	parameter int NUM_WAYS    = 4,
	parameter int OFFSET_BITS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [ADDR_W-1:0]    address,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 hit,
	output logic [OUT_WAY_W-1:0] way,
	output logic                 evicted,
	output logic [CNT_W-1:0]     reference_count,
	output logic [CNT_W-1:0]     miss_count,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	sacf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sacf_dpath #(
		.NUM_SETS    (NUM_SETS),
		.NUM_WAYS    (NUM_WAYS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.address         (address),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.hit             (hit),
		.way             (way),
		.evicted         (evicted),
		.reference_count (reference_count),
		.miss_count      (miss_count)
	);

	// One word at a time: the cycle after an accept is a lookup
	`SACF_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, req_valid && !req_stall, req_stall)
	// No word is taken during the clearing pass
	`SACF_ASSERT_NOW(a_clear_stalls, clk, arst_n, cmd.clear_en, req_stall)
	// A write-back always presents a result next cycle
	`SACF_ASSERT_NEXT(a_update_shows, clk, arst_n, cmd.update, rsp_valid)
	// An eviction only happens on a miss
	`SACF_ASSERT_NOW(a_evict_on_miss, clk, arst_n, rsp_valid && evicted, !hit)

endmodule

// ===== test/tb_set_assoc_cache_fifo_random.sv =====
`timescale 1ns / 100ps

module tb_set_assoc_cache_fifo_random;
	import sacf_pkg::*;

	localparam int SETS           = 1024;
	localparam int WAYS           = 4;
	localparam int OFFS           = 6;
	localparam int LINES          = SETS * WAYS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_WORDS    = 225;

	// One expected lookup outcome
	typedef struct packed {
		logic                 hit;
		logic [OUT_WAY_W-1:0] way;
		logic                 evicted;
		logic [CNT_W-1:0]     refs;
		logic [CNT_W-1:0]     misses;
	} lookup_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [ADDR_W-1:0]    address = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic                 hit;
	logic [OUT_WAY_W-1:0] way;
	logic                 evicted;
	logic [CNT_W-1:0]     reference_count;
	logic [CNT_W-1:0]     miss_count;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_POLICY;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// Shadow copy of the tag store and counters
	bit                   shadow_valid [LINES];
	logic [TAG_W-1:0]     shadow_tag [LINES];
	logic [AGE_W-1:0]     shadow_age [LINES];
	logic [LFSR_W-1:0]    shadow_lfsr;
	logic [CNT_W-1:0]     refs_total;
	logic [CNT_W-1:0]     misses_total;
	bit                   random_policy;

	lookup_result_t       pending_lookups [$];
	int                   mismatch_count = 0;
	int                   result_index = 0;
	int                   send_idle_pct = 0;
	int                   rsp_stall_pct = 0;
	int                   quiet_cycles = 0;

	set_assoc_cache_fifo_random dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.address         (address),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.hit             (hit),
		.way             (way),
		.evicted         (evicted),
		.reference_count (reference_count),
		.miss_count      (miss_count),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		mismatch_count++;
	endtask

	function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] nxt;
		nxt = v >> 1;
		if (v[0])
			nxt = nxt ^ LFSR_TAPS;
		return nxt;
	endfunction

	function automatic logic [ADDR_W-1:0] line_address(input int set_sel,
		input logic [TAG_W-1:0] tag_sel);
		logic [9:0] set_bits;
		logic [OFFS-1:0] offs;
		set_bits = set_sel[9:0];
		offs = OFFS'($urandom_range(63));
		return {tag_sel, set_bits, offs};
	endfunction

	// Clear the shadow store to its reset contents
	task automatic reset_shadow();
		for (int i = 0; i < LINES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_tag[i] = '0;
			shadow_age[i] = '0;
		end
		shadow_lfsr = SEED_DEFAULT;
		refs_total = '0;
		misses_total = '0;
		random_policy = 1'b0;
	endtask

	// Look up one address in the shadow store and apply the fill or replacement
	function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] a);
		lookup_result_t r;
		logic [ADDR_W-OFFS-1:0] blk;
		logic [TAG_W-1:0] tag_val;
		logic [AGE_W-1:0] best;
		int base;
		int sel;
		bit found;
		blk = a[ADDR_W-1:OFFS];
		tag_val = blk[25:10];
		base = int'(blk[9:0]) * WAYS;
		sel = 0;
		found = 1'b0;
		r = '0;
		refs_total++;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag_val) begin
				found = 1'b1;
				sel = w;
			end
		end
		r.hit = found;
		if (!found) begin
			misses_total++;
			for (int w = WAYS - 1; w >= 0; w--) begin
				if (!shadow_valid[base + w]) begin
					sel = w;
					found = 1'b1;
				end
			end
			// Set full: pick a victim
			if (!found) begin
				r.evicted = 1'b1;
				if (random_policy) begin
					shadow_lfsr = lfsr_advance(shadow_lfsr);
					sel = int'(shadow_lfsr[1:0]);
				end else begin
					best = '0;
					sel = 0;
					for (int w = 0; w < WAYS; w++) begin
						if (shadow_age[base + w] > best) begin
							best = shadow_age[base + w];
							sel = w;
						end
					end
					for (int w = 0; w < WAYS; w++) begin
						if (w != sel)
							shadow_age[base + w] = shadow_age[base + w] + 1'b1;
					end
				end
			end
			shadow_valid[base + sel] = 1'b1;
			shadow_tag[base + sel] = tag_val;
			shadow_age[base + sel] = '0;
		end
		r.way = sel[1:0];
		r.refs = refs_total;
		r.misses = misses_total;
		return r;
	endfunction

	// Offer one address word, with random gaps, and hold it until taken
	task automatic send_address(input logic [ADDR_W-1:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		address <= a;
		do
			@(posedge clk);
		while (!(req_valid && !req_stall));
		pending_lookups.push_back(predict_lookup(a));
	endtask

	// Drop valid and wait until every expected result is out
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_POLICY)
			random_policy = data[0];
		else if (idx == REG_SEED)
			shadow_lfsr = (data != '0) ? data : SEED_DEFAULT;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reset defaults: fill, hit, then oldest-first eviction with ties and all-zero ages
	task automatic test_fifo_fill_and_evict();
		send_address(32'h0000_0000);
		send_address(32'h0000_003f);
		send_address(32'hffff_ffff);
		send_address(line_address(0, 16'h0001));
		send_address(line_address(0, 16'h0002));
		send_address(line_address(0, 16'h0003));
		send_address(line_address(0, 16'hffff));
		send_address(line_address(0, 16'h1234));
		send_address(line_address(0, 16'hffff));
		send_address(line_address(0, 16'h0000));
		wait_drained();
	endtask

	// Random victims: zero seed, extreme seeds, policy with upper bits set
	task automatic test_random_victims();
		write_register(REG_POLICY, 16'h0001);
		write_register(REG_SEED, 16'h0000);
		for (int t = 0; t < 4; t++)
			send_address(line_address(5, TAG_W'(16'h0010 + t)));
		for (int t = 0; t < 3; t++)
			send_address(line_address(5, TAG_W'(16'h0020 + t)));
		wait_drained();
		write_register(REG_SEED, 16'hffff);
		send_address(line_address(5, 16'h0030));
		send_address(line_address(5, 16'h0031));
		wait_drained();
		write_register(REG_POLICY, 16'hfffe);
		send_address(line_address(5, 16'h0040));
		wait_drained();
		write_register(REG_POLICY, 16'h0003);
		write_register(REG_SEED, 16'h0001);
		send_address(line_address(5, 16'h0041));
		wait_drained();
	endtask

	// One burst of traffic focused on a few hot sets, with some noise addresses
	task automatic run_traffic_phase(input int idle_pct, input int stall_pct, input int count);
		int hot_sets [8];
		logic [TAG_W-1:0] hot_tags [6];
		for (int i = 0; i < 8; i++)
			hot_sets[i] = $urandom_range(SETS - 1);
		hot_sets[0] = 0;
		hot_sets[1] = SETS - 1;
		for (int i = 0; i < 6; i++)
			hot_tags[i] = TAG_W'($urandom_range(16'hffff));
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count) begin
			if ($urandom_range(99) < 80)
				send_address(line_address(hot_sets[$urandom_range(7)],
					hot_tags[$urandom_range(5)]));
			else
				send_address($urandom());
		end
		wait_drained();
	endtask

	// Sweep both policies over all idle and stall mixes, reseeding each phase
	task automatic test_mixed_traffic();
		int idle_mix [4] = '{0, 48, 0, 22};
		int stall_mix [4] = '{0, 0, 48, 22};
		logic [CFG_DAT_W-1:0] seed_val;
		logic [CFG_DAT_W-1:0] policy_val;
		for (int pol = 0; pol < 2; pol++) begin
			for (int ph = 0; ph < 4; ph++) begin
				policy_val = CFG_DAT_W'($urandom_range(16'hffff));
				policy_val[0] = pol[0];
				case (ph)
					0: seed_val = 16'h0001;
					1: seed_val = 16'hffff;
					2: seed_val = 16'h0000;
					default: seed_val = CFG_DAT_W'($urandom_range(16'hffff));
				endcase
				write_register(REG_POLICY, policy_val);
				write_register(REG_SEED, seed_val);
				run_traffic_phase(idle_mix[ph], stall_mix[ph], PHASE_WORDS);
			end
		end
		send_idle_pct = 0;
		rsp_stall_pct = 0;
	endtask

	// Stall the result side at random
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

	// Compare each taken result word with the oldest expectation
	always @(posedge clk) begin : check_result
		lookup_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected: hit %0b way %0d",
					result_index, hit, way));
			end else begin
				want = pending_lookups.pop_front();
				if (hit !== want.hit)
					report_mismatch($sformatf("result %0d hit: got %0b expected %0b",
						result_index, hit, want.hit));
				if (way !== want.way)
					report_mismatch($sformatf("result %0d way: got %0d expected %0d",
						result_index, way, want.way));
				if (evicted !== want.evicted)
					report_mismatch($sformatf("result %0d evicted: got %0b expected %0b",
						result_index, evicted, want.evicted));
				if (reference_count !== want.refs)
					report_mismatch($sformatf("result %0d reference_count: got %0d expected %0d",
						result_index, reference_count, want.refs));
				if (miss_count !== want.misses)
					report_mismatch($sformatf("result %0d miss_count: got %0d expected %0d",
						result_index, miss_count, want.misses));
			end
			result_index++;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		reset_shadow();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fifo_fill_and_evict();
		test_random_victims();
		test_mixed_traffic();
		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_lookups.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_lookups.size()));
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
